>>> rtl/tce_pkg.sv
// Shared types, codes and field widths of the TCP connection engine.
`timescale 1ns / 1ps
package tce_pkg;

    localparam int IN_DATA_W  = 232;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 192;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [5:0] FLAG_URG = 6'h20;
    localparam logic [5:0] FLAG_ACK = 6'h10;
    localparam logic [5:0] FLAG_PSH = 6'h08;
    localparam logic [5:0] FLAG_RST = 6'h04;
    localparam logic [5:0] FLAG_SYN = 6'h02;
    localparam logic [5:0] FLAG_FIN = 6'h01;

    localparam logic [3:0] CONN_CLOSED  = 4'd0;
    localparam logic [3:0] CONN_LISTEN  = 4'd1;
    localparam logic [3:0] CONN_SYNRCVD = 4'd2;
    localparam logic [3:0] CONN_ESTAB   = 4'd3;

    localparam logic [2:0] ACT_DROP   = 3'd0;
    localparam logic [2:0] ACT_RESET  = 3'd1;
    localparam logic [2:0] ACT_ACK    = 3'd2;
    localparam logic [2:0] ACT_SYNACK = 3'd3;
    localparam logic [2:0] ACT_FINACK = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOMATCH = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_CLOSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREF_WIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSS        = 2'd2;

    typedef struct packed {
        logic [3:0]  state;
        logic [31:0] laddr;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [15:0] rport;
        logic [31:0] snd_isn;
        logic [31:0] snd_nxt;
        logic [31:0] snd_una;
        logic [15:0] snd_wnd;
        logic [31:0] wl_seq;
        logic [31:0] wl_ack;
        logic [31:0] rcv_nxt;
        logic [15:0] rcv_wnd;
        logic [15:0] ip_id;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic        opcode;
        logic        cksum_ok;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0]  flags;
        logic [15:0] wnd;
        logic [15:0] len;
        logic [31:0] isn;
    } seg_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0]  flags;
        logic [15:0] window;
        logic [15:0] ip_id;
        logic [31:0] raddr;
        logic [15:0] rport;
        logic [15:0] lport;
        logic [15:0] deliver;
        logic [3:0]  slot;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic rd_sel;
        logic load;
        logic check;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic again;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/tce_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

>>> rtl/tce_ctrl.sv
// Sequencer of the TCP connection engine: scan, load, check, execute.
`timescale 1ns / 1ps
module tce_ctrl import tce_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_RDSEL = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_EXEC  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.start = s_tvalid;
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_RDSEL;
            ST_RDSEL: begin
                cmd.rd_sel = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.again) state_next = ST_CHECK;
                else if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

>>> rtl/tce_datapath.sv
// Slot table, match scan and segment processing of the TCP connection engine.
`timescale 1ns / 1ps
module tce_datapath import tce_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,
    input  cmd_t                  cmd,
    output stat_t                 stat
);
    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    function automatic logic sq_ge(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

    function automatic logic sq_gt(input logic [31:0] a, input logic [31:0] b);
        return (a != b) && sq_ge(a, b);
    endfunction

    function automatic res_t rst_reply(input seg_t g, input logic [3:0] sl,
                                       input logic [1:0] st);
        res_t r;
        r        = '0;
        r.slot   = sl;
        r.status = st;
        if ((g.flags & FLAG_RST) == 6'd0) begin
            r.action = ACT_RESET;
            if ((g.flags & FLAG_ACK) != 6'd0) begin
                r.seq   = g.ack;
                r.flags = FLAG_RST;
            end else begin
                r.ack   = g.seq + {16'd0, g.len}
                        + {31'd0, ((g.flags & (FLAG_SYN | FLAG_FIN)) != 6'd0)};
                r.flags = FLAG_RST | FLAG_ACK;
            end
            r.raddr = g.src;
            r.rport = g.sport;
            r.lport = g.dport;
        end
        return r;
    endfunction

    function automatic res_t ack_res(input slot_t w, input logic [3:0] sl);
        res_t r;
        r        = '0;
        r.action = ACT_ACK;
        r.seq    = w.snd_nxt;
        r.ack    = w.rcv_nxt;
        r.flags  = FLAG_ACK;
        r.window = w.rcv_wnd;
        r.ip_id  = w.ip_id;
        r.raddr  = w.raddr;
        r.rport  = w.rport;
        r.lport  = w.lport;
        r.slot   = sl;
        return r;
    endfunction

    function automatic slot_t close_slot(input slot_t w);
        slot_t c;
        c       = w;
        c.laddr = '0;
        c.lport = '0;
        c.raddr = '0;
        c.rport = '0;
        c.state = CONN_CLOSED;
        return c;
    endfunction

    // configuration
    logic [31:0] local_addr_reg;
    logic [15:0] pref_reg, mss_reg;

    seg_t seg_reg;

    // scan
    logic [SW-1:0] scan_idx_reg, cmp_idx_reg;
    logic          cmp_vld_reg;
    logic          hit_found_reg, lis_found_reg, free_found_reg;
    logic [SW-1:0] hit_idx_reg, lis_idx_reg, free_idx_reg;
    logic [SW-1:0] sel_idx, rd_addr;

    // table
    logic [SLOTS-1:0] valid_reg;
    logic             vld_q_reg;
    logic [SLOT_W-1:0] ram_q;
    slot_t            rec;

    // working slot and checks
    slot_t        w_reg, w_next;
    logic         inwin_reg, ack_gt_nxt_reg, una_gt_ack_reg, ack_gt_una_reg;
    logic         ack_ge_una_reg, seq_gt_wl_reg, seq_eq_wl_reg, ack_ge_wl_reg;
    logic         rexp_eq_seq_reg;
    logic [15:0]  len_clip_reg, wnd_adv_reg, wnd_sub_reg, isn_mod_reg;
    logic signed [17:0] diff_reg;

    // check stage logic
    logic [31:0] d_lo, d_hi;
    logic        inwin_c;
    logic [15:0] len_clip_c;
    logic [16:0] mod_fold;
    logic [15:0] mod_sum;

    // execute stage logic
    res_t        res_c, res_reg;
    slot_t       upd;
    logic        wr_en_c, again_c, fire, adv_c;
    logic [SW-1:0] wr_idx_c;
    slot_t       wr_rec_c;
    logic [15:0] thr_c;
    logic [3:0]  slot_c;
    logic        m_valid_reg;

    // sensing of the match on the record coming out of the RAM
    logic loc_m, full_m;

    assign sel_idx = seg_reg.opcode ? free_idx_reg
                   : (hit_found_reg ? hit_idx_reg : lis_idx_reg);
    assign rd_addr = cmd.scan ? scan_idx_reg : sel_idx;
    assign rec     = vld_q_reg ? slot_t'(ram_q) : slot_t'('0);

    assign loc_m  = (seg_reg.dst == rec.laddr) && (seg_reg.dport == rec.lport);
    assign full_m = loc_m && (seg_reg.src == rec.raddr) && (seg_reg.sport == rec.rport);

    tce_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_table (
        .aclk    (aclk),
        .wr_en   (fire && wr_en_c),
        .wr_addr (wr_idx_c),
        .wr_data (wr_rec_c),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // receive window test, data clipping, ident seed
    always_comb begin
        d_lo = seg_reg.seq - w_reg.rcv_nxt;
        d_hi = seg_reg.seq + {16'd0, seg_reg.len} - 32'd1 - w_reg.rcv_nxt;
        if (seg_reg.len == 16'd0) begin
            if (w_reg.rcv_wnd == 16'd0) inwin_c = (seg_reg.seq == w_reg.rcv_nxt);
            else inwin_c = (d_lo < {16'd0, w_reg.rcv_wnd});
        end else if (w_reg.rcv_wnd == 16'd0) begin
            inwin_c = 1'b0;
        end else begin
            inwin_c = (d_lo < {16'd0, w_reg.rcv_wnd}) || (d_hi < {16'd0, w_reg.rcv_wnd});
        end
        len_clip_c = (seg_reg.len > w_reg.rcv_wnd) ? w_reg.rcv_wnd : seg_reg.len;
        // fold the seed modulo 2^16 - 1
        mod_fold = {1'b0, seg_reg.isn[31:16]} + {1'b0, seg_reg.isn[15:0]};
        mod_sum  = mod_fold[15:0] + {15'd0, mod_fold[16]};
    end

    assign slot_c = 4'(sel_idx);
    assign thr_c  = (mss_reg < {1'b0, pref_reg[15:1]}) ? mss_reg : {1'b0, pref_reg[15:1]};
    assign adv_c  = diff_reg >= $signed({2'b00, thr_c});

    always_comb begin
        res_c    = '0;
        wr_en_c  = 1'b0;
        wr_idx_c = sel_idx;
        wr_rec_c = w_reg;
        again_c  = 1'b0;
        w_next   = w_reg;
        upd      = w_reg;
        if (seg_reg.opcode) begin
            if (!free_found_reg) begin
                res_c.status = STATUS_FULL;
            end else begin
                wr_en_c        = 1'b1;
                wr_rec_c.laddr = local_addr_reg;
                wr_rec_c.lport = seg_reg.dport;
                wr_rec_c.raddr = '0;
                wr_rec_c.rport = '0;
                wr_rec_c.state = CONN_LISTEN;
                res_c.lport    = seg_reg.dport;
                res_c.slot     = 4'(free_idx_reg);
            end
        end else if (!seg_reg.cksum_ok) begin
            res_c = '0;
        end else if (!(hit_found_reg || lis_found_reg)) begin
            res_c = rst_reply(seg_reg, 4'd0, STATUS_NOMATCH);
        end else begin
            res_c.slot = slot_c;
            case (w_reg.state)
                CONN_LISTEN: begin
                    if (((seg_reg.flags & FLAG_SYN) == 6'd0) ||
                        ((seg_reg.flags & (FLAG_ACK | FLAG_RST | FLAG_FIN)) != 6'd0)) begin
                        res_c = rst_reply(seg_reg, slot_c, STATUS_OK);
                    end else if (!free_found_reg) begin
                        res_c = rst_reply(seg_reg, slot_c, STATUS_FULL);
                    end else begin
                        wr_en_c          = 1'b1;
                        wr_idx_c         = free_idx_reg;
                        wr_rec_c.raddr   = seg_reg.src;
                        wr_rec_c.rport   = seg_reg.sport;
                        wr_rec_c.snd_isn = seg_reg.isn;
                        wr_rec_c.snd_una = seg_reg.isn;
                        wr_rec_c.snd_nxt = seg_reg.isn + 32'd1;
                        wr_rec_c.rcv_nxt = seg_reg.seq + 32'd1;
                        wr_rec_c.ip_id   = isn_mod_reg + 16'd1;
                        wr_rec_c.state   = CONN_SYNRCVD;
                        res_c.action     = ACT_SYNACK;
                        res_c.seq        = seg_reg.isn;
                        res_c.ack        = seg_reg.seq + 32'd1;
                        res_c.flags      = FLAG_SYN | FLAG_ACK;
                        res_c.window     = w_reg.rcv_wnd;
                        res_c.ip_id      = isn_mod_reg;
                        res_c.raddr      = seg_reg.src;
                        res_c.rport      = seg_reg.sport;
                        res_c.lport      = w_reg.lport;
                        res_c.slot       = 4'(free_idx_reg);
                    end
                end
                CONN_SYNRCVD: begin
                    if (!inwin_reg) begin
                        if ((seg_reg.flags & FLAG_RST) == 6'd0) begin
                            res_c          = ack_res(w_reg, slot_c);
                            wr_en_c        = 1'b1;
                            wr_rec_c.ip_id = w_reg.ip_id + 16'd1;
                        end
                    end else if ((seg_reg.flags & FLAG_SYN) != 6'd0) begin
                        wr_en_c      = 1'b1;
                        wr_rec_c     = close_slot(w_reg);
                        res_c.status = STATUS_CLOSED;
                    end else if ((seg_reg.flags & FLAG_ACK) == 6'd0) begin
                        res_c.action = ACT_DROP;
                    end else if (ack_gt_nxt_reg || una_gt_ack_reg) begin
                        res_c = rst_reply(seg_reg, slot_c, STATUS_OK);
                    end else begin
                        // move to established and run the segment again
                        again_c        = 1'b1;
                        w_next.snd_wnd = seg_reg.wnd;
                        w_next.wl_seq  = seg_reg.seq;
                        w_next.wl_ack  = seg_reg.ack;
                        w_next.rcv_wnd = pref_reg;
                        w_next.state   = CONN_ESTAB;
                    end
                end
                CONN_ESTAB: begin
                    if (!inwin_reg) begin
                        if ((seg_reg.flags & FLAG_RST) == 6'd0) begin
                            res_c          = ack_res(w_reg, slot_c);
                            wr_en_c        = 1'b1;
                            wr_rec_c.ip_id = w_reg.ip_id + 16'd1;
                        end
                    end else if ((seg_reg.flags & (FLAG_RST | FLAG_SYN)) != 6'd0) begin
                        wr_en_c      = 1'b1;
                        wr_rec_c     = close_slot(w_reg);
                        res_c.status = STATUS_CLOSED;
                    end else if ((seg_reg.flags & FLAG_ACK) == 6'd0) begin
                        res_c.action = ACT_DROP;
                    end else if (ack_gt_nxt_reg) begin
                        res_c          = ack_res(w_reg, slot_c);
                        wr_en_c        = 1'b1;
                        wr_rec_c.ip_id = w_reg.ip_id + 16'd1;
                    end else begin
                        if (ack_gt_una_reg) upd.snd_una = seg_reg.ack;
                        if (ack_ge_una_reg &&
                            (seq_gt_wl_reg || (seq_eq_wl_reg && ack_ge_wl_reg))) begin
                            upd.snd_wnd = seg_reg.wnd;
                            upd.wl_seq  = seg_reg.seq;
                            upd.wl_ack  = seg_reg.ack;
                        end
                        wr_en_c = 1'b1;
                        if ((seg_reg.flags & FLAG_FIN) != 6'd0) begin
                            res_c        = ack_res(upd, slot_c);
                            res_c.action = ACT_FINACK;
                            res_c.ack    = seg_reg.seq + 32'd1;
                            res_c.flags  = FLAG_ACK | FLAG_FIN;
                            res_c.status = STATUS_CLOSED;
                            upd.ip_id    = upd.ip_id + 16'd1;
                            wr_rec_c     = close_slot(upd);
                        end else begin
                            if ((seg_reg.len != 16'd0) && rexp_eq_seq_reg) begin
                                upd.rcv_wnd = adv_c ? wnd_adv_reg : wnd_sub_reg;
                                upd.rcv_nxt = upd.rcv_nxt + {16'd0, len_clip_reg};
                            end
                            res_c = ack_res(upd, slot_c);
                            if ((seg_reg.len != 16'd0) && rexp_eq_seq_reg) begin
                                res_c.deliver = len_clip_reg;
                            end
                            upd.ip_id = upd.ip_id + 16'd1;
                            wr_rec_c  = upd;
                        end
                    end
                end
                default: res_c = rst_reply(seg_reg, slot_c, STATUS_NOMATCH);
            endcase
        end
    end

    assign fire = cmd.exec && !again_c && (!m_valid_reg || m_tready);

    assign stat.scan_last = (scan_idx_reg == LAST_IDX);
    assign stat.again     = again_c;
    assign stat.out_free  = !m_valid_reg || m_tready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg <= '0;
            pref_reg       <= 16'd8192;
            mss_reg        <= 16'd536;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            scan_idx_reg   <= '0;
            hit_found_reg  <= 1'b0;
            lis_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LOCAL_ADDR: local_addr_reg <= cfg_data;
                    CFG_PREF_WIN:   pref_reg       <= cfg_data[15:0];
                    CFG_MSS:        mss_reg        <= cfg_data[15:0];
                    default: ;
                endcase
            end
            cmp_vld_reg <= cmd.scan;
            if (cmd.start) begin
                scan_idx_reg   <= '0;
                hit_found_reg  <= 1'b0;
                lis_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (cmd.scan) scan_idx_reg <= scan_idx_reg + 1'b1;
                if (cmp_vld_reg) begin
                    if (!hit_found_reg && loc_m && rec.state == CONN_LISTEN) lis_found_reg <= 1'b1;
                    if (full_m) hit_found_reg <= 1'b1;
                    if (rec.state == CONN_CLOSED) free_found_reg <= 1'b1;
                end
            end
            if (fire && wr_en_c) valid_reg[wr_idx_c] <= 1'b1;
            if (fire) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        vld_q_reg   <= valid_reg[rd_addr];
        cmp_idx_reg <= scan_idx_reg;
        if (cmd.start) begin
            seg_reg.opcode   <= s_tuser[0];
            seg_reg.cksum_ok <= s_tuser[1];
            seg_reg.src      <= s_tdata[31:0];
            seg_reg.dst      <= s_tdata[63:32];
            seg_reg.sport    <= s_tdata[79:64];
            seg_reg.dport    <= s_tdata[95:80];
            seg_reg.seq      <= s_tdata[127:96];
            seg_reg.ack      <= s_tdata[159:128];
            seg_reg.flags    <= s_tdata[165:160];
            seg_reg.wnd      <= s_tdata[181:166];
            seg_reg.len      <= s_tdata[197:182];
            seg_reg.isn      <= s_tdata[229:198];
        end
        if (cmp_vld_reg && !cmd.start) begin
            if (!hit_found_reg && loc_m && rec.state == CONN_LISTEN) lis_idx_reg <= cmp_idx_reg;
            if (!hit_found_reg && full_m) hit_idx_reg <= cmp_idx_reg;
            if (!free_found_reg && rec.state == CONN_CLOSED) free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.load) w_reg <= rec;
        else if (cmd.exec && again_c) w_reg <= w_next;
        if (cmd.check) begin
            inwin_reg       <= inwin_c;
            ack_gt_nxt_reg  <= sq_gt(seg_reg.ack, w_reg.snd_nxt);
            una_gt_ack_reg  <= sq_gt(w_reg.snd_una, seg_reg.ack);
            ack_gt_una_reg  <= sq_gt(seg_reg.ack, w_reg.snd_una);
            ack_ge_una_reg  <= sq_ge(seg_reg.ack, w_reg.snd_una);
            seq_gt_wl_reg   <= sq_gt(seg_reg.seq, w_reg.wl_seq);
            seq_eq_wl_reg   <= (seg_reg.seq == w_reg.wl_seq);
            ack_ge_wl_reg   <= sq_ge(seg_reg.ack, w_reg.wl_ack);
            rexp_eq_seq_reg <= (w_reg.rcv_nxt == seg_reg.seq);
            len_clip_reg    <= len_clip_c;
            wnd_adv_reg     <= pref_reg - len_clip_c;
            wnd_sub_reg     <= w_reg.rcv_wnd - len_clip_c;
            diff_reg        <= $signed({2'b00, pref_reg}) - $signed({2'b00, w_reg.rcv_wnd})
                             - $signed({2'b00, len_clip_c});
            isn_mod_reg     <= (mod_sum == 16'hFFFF) ? 16'd0 : mod_sum;
        end
        if (fire) res_reg <= res_c;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.action;
    assign m_tdata  = {4'd0, res_reg.status, res_reg.slot, res_reg.deliver,
                       res_reg.lport, res_reg.rport, res_reg.raddr, res_reg.ip_id,
                       res_reg.window, res_reg.flags, res_reg.ack, res_reg.seq};
endmodule

>>> rtl/tcp_connection_engine.sv
// Top level of the TCP connection engine: sequencer plus slot-table datapath.
`timescale 1ns / 1ps
// Flow: after the accepting edge the scan reads the slot table, one slot per cycle through
//   the table RAM read port; drain, read-select, load, check and execute states follow.
//   Completing the SYN-RECEIVED handshake runs the check/execute pair twice. Execute waits
//   on a stalled full output; s_tready stays low until the sequencer is back in idle.
// Reset: synchronous, active-low; clears the sequencer, the output valid and the per-slot
//   valid bits, so every slot reads as closed and zero; sets the configuration to defaults.
module tcp_connection_engine import tce_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata, from bit 0: src_addr, dst_addr, src_port, dest_port, seq_num, ack_num,
    //   seg_flags, seg_window, data_len, initial_seq, zero fill
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser, from bit 0: opcode, checksum_ok
    input  logic [IN_USER_W-1:0]  s_tuser,
    // m_tdata, from bit 0: out_seq, out_ack, out_flags, out_window, out_ip_id,
    //   out_remote_addr, out_remote_port, out_local_port, deliver_len, slot, status, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // m_tuser: action
    output logic [OUT_USER_W-1:0] m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    cmd_t  cmd;
    stat_t stat;

    // Sequencer: one transaction at a time through scan, load, check, execute.
    tce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: slot table RAM, match scan, state steps and output register.
    tce_datapath #(.SLOTS(SLOTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule

>>> rtl/tce_checker.sv
// Port-level checks of the TCP connection engine and their binding.
`timescale 1ns / 1ps
module tce_checker import tce_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [IN_USER_W-1:0]  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);
    // one transaction in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a transaction is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_action_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ACT_FINACK)
        else $error("action code out of range");

    a_reset_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ACT_RESET |-> m_tdata[101:86] == 16'd0 && m_tdata[85:70] == 16'd0)
        else $error("reset reply carries an ident or window");

    a_full_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[187:186] == STATUS_FULL |-> m_tuser == ACT_DROP || m_tuser == ACT_RESET)
        else $error("table-full status with a slot reply");
endmodule

bind tcp_connection_engine tce_checker u_tce_checker (.*);

>>> tb/tb_tcp_connection_engine.sv
// Self-checking testbench for the TCP connection engine top level.
`timescale 1ns / 1ps
module tb_tcp_connection_engine;
    import tce_pkg::*;

    logic                  aclk;
    logic                  aresetn    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic [IN_USER_W-1:0]  s_tuser    = '0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    tcp_connection_engine #(.SLOTS(16)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Segments waiting for the driver, and replies predicted for accepted segments.
    seg_t pending_segs[$];
    res_t expected_replies[$];
    int   mismatches = 0;
    int   snd_idle_pct = 0;
    int   rcv_stall_pct = 0;

    // Shadow of the configuration registers.
    logic [31:0] sh_local_addr = 32'd0;
    logic [15:0] sh_pref_win   = 16'd8192;
    logic [15:0] sh_mss        = 16'd536;

    // Shadow connection table, cleared as after reset.
    logic [3:0]  tbl_state   [16] = '{default: '0};
    logic [31:0] tbl_laddr   [16] = '{default: '0};
    logic [15:0] tbl_lport   [16] = '{default: '0};
    logic [31:0] tbl_raddr   [16] = '{default: '0};
    logic [15:0] tbl_rport   [16] = '{default: '0};
    logic [31:0] tbl_isn     [16] = '{default: '0};
    logic [31:0] tbl_snd_nxt [16] = '{default: '0};
    logic [31:0] tbl_snd_una [16] = '{default: '0};
    logic [15:0] tbl_snd_wnd [16] = '{default: '0};
    logic [31:0] tbl_wl_seq  [16] = '{default: '0};
    logic [31:0] tbl_wl_ack  [16] = '{default: '0};
    logic [31:0] tbl_rcv_nxt [16] = '{default: '0};
    logic [15:0] tbl_rcv_wnd [16] = '{default: '0};
    logic [15:0] tbl_ip_id   [16] = '{default: '0};

    // Generator bookkeeping: listeners the stimulus knows about.
    logic [31:0] lst_addr[$];
    logic [15:0] lst_port[$];
    int          items_sent = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Serial (mod 2^32) sequence comparisons.
    function automatic bit seq_ge(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

    function automatic bit seq_gt(logic [31:0] a, logic [31:0] b);
        return (a != b) && seq_ge(a, b);
    endfunction

    function automatic int first_closed();
        for (int i = 0; i < 16; i++)
            if (tbl_state[i] == CONN_CLOSED) return i;
        return -1;
    endfunction

    function automatic void close_conn(int s);
        tbl_laddr[s] = '0; tbl_lport[s] = '0;
        tbl_raddr[s] = '0; tbl_rport[s] = '0;
        tbl_state[s] = CONN_CLOSED;
    endfunction

    function automatic void reset_reply(seg_t it, inout res_t r);
        if ((it.flags & FLAG_RST) != 0) begin
            r.action = ACT_DROP;
            return;
        end
        r.action = ACT_RESET;
        if ((it.flags & FLAG_ACK) != 0) begin
            r.seq = it.ack; r.ack = '0; r.flags = FLAG_RST;
        end else begin
            r.seq = '0;
            r.ack = it.seq + {16'd0, it.len} + (((it.flags & (FLAG_SYN | FLAG_FIN)) != 0) ? 1 : 0);
            r.flags = FLAG_RST | FLAG_ACK;
        end
        r.window = '0; r.ip_id = '0;
        r.raddr = it.src; r.rport = it.sport; r.lport = it.dport;
    endfunction

    function automatic void conn_reply(int s, logic [2:0] act, logic [31:0] sq,
                                       logic [31:0] ak, logic [5:0] fl, inout res_t r);
        r.action = act; r.seq = sq; r.ack = ak; r.flags = fl;
        r.window = tbl_rcv_wnd[s];
        r.ip_id = tbl_ip_id[s];
        tbl_ip_id[s] = tbl_ip_id[s] + 16'd1;
        r.raddr = tbl_raddr[s]; r.rport = tbl_rport[s]; r.lport = tbl_lport[s];
    endfunction

    function automatic bit seg_in_window(int s, logic [31:0] sq, logic [31:0] len);
        logic [31:0] w;
        logic [31:0] d;
        logic [31:0] d2;
        w = {16'd0, tbl_rcv_wnd[s]};
        d = sq - tbl_rcv_nxt[s];
        d2 = sq + len - 32'd1 - tbl_rcv_nxt[s];
        if (len == 0) return (w == 0) ? (sq == tbl_rcv_nxt[s]) : (d < w);
        if (w == 0) return 1'b0;
        return (d < w) || (d2 < w);
    endfunction

    function automatic void step_estab(int s, seg_t it, inout res_t r);
        logic [31:0] len;
        int pref, wnd, thr;
        len = {16'd0, it.len};
        if (!seg_in_window(s, it.seq, len)) begin
            if ((it.flags & FLAG_RST) == 0)
                conn_reply(s, ACT_ACK, tbl_snd_nxt[s], tbl_rcv_nxt[s], FLAG_ACK, r);
            return;
        end
        if ((it.flags & (FLAG_RST | FLAG_SYN)) != 0) begin
            close_conn(s); r.status = STATUS_CLOSED; return;
        end
        if ((it.flags & FLAG_ACK) == 0) return;
        if (seq_gt(it.ack, tbl_snd_nxt[s])) begin
            conn_reply(s, ACT_ACK, tbl_snd_nxt[s], tbl_rcv_nxt[s], FLAG_ACK, r);
            return;
        end
        if (seq_gt(it.ack, tbl_snd_una[s])) tbl_snd_una[s] = it.ack;
        if (seq_ge(it.ack, tbl_snd_una[s])) begin
            if (seq_gt(it.seq, tbl_wl_seq[s]) ||
                (it.seq == tbl_wl_seq[s] && seq_ge(it.ack, tbl_wl_ack[s]))) begin
                tbl_snd_wnd[s] = it.wnd;
                tbl_wl_seq[s] = it.seq;
                tbl_wl_ack[s] = it.ack;
            end
        end
        if ((it.flags & FLAG_FIN) != 0) begin
            conn_reply(s, ACT_FINACK, tbl_snd_nxt[s], it.seq + 32'd1, FLAG_ACK | FLAG_FIN, r);
            close_conn(s);
            r.status = STATUS_CLOSED;
            return;
        end
        if (len > 0) begin
            if (tbl_rcv_nxt[s] != it.seq) begin
                conn_reply(s, ACT_ACK, tbl_snd_nxt[s], tbl_rcv_nxt[s], FLAG_ACK, r);
                return;
            end
            if (tbl_rcv_wnd[s] < len) len = {16'd0, tbl_rcv_wnd[s]};
            // Open the window back to the preferred size once the gain is worth it.
            pref = sh_pref_win;
            wnd = tbl_rcv_wnd[s];
            thr = pref / 2;
            if (int'(sh_mss) < thr) thr = sh_mss;
            if (pref - wnd - int'(len) >= thr) tbl_rcv_wnd[s] = sh_pref_win - len[15:0];
            else tbl_rcv_wnd[s] = tbl_rcv_wnd[s] - len[15:0];
            tbl_rcv_nxt[s] = tbl_rcv_nxt[s] + len;
            r.deliver = len[15:0];
        end
        conn_reply(s, ACT_ACK, tbl_snd_nxt[s], tbl_rcv_nxt[s], FLAG_ACK, r);
    endfunction

    function automatic void step_synrcvd(int s, seg_t it, inout res_t r);
        if (!seg_in_window(s, it.seq, {16'd0, it.len})) begin
            if ((it.flags & FLAG_RST) == 0)
                conn_reply(s, ACT_ACK, tbl_snd_nxt[s], tbl_rcv_nxt[s], FLAG_ACK, r);
            return;
        end
        if ((it.flags & FLAG_SYN) != 0) begin
            close_conn(s); r.status = STATUS_CLOSED; return;
        end
        if ((it.flags & FLAG_ACK) == 0) return;
        if (seq_gt(it.ack, tbl_snd_nxt[s]) || seq_gt(tbl_snd_una[s], it.ack)) begin
            reset_reply(it, r);
            return;
        end
        tbl_snd_wnd[s] = it.wnd;
        tbl_wl_seq[s] = it.seq;
        tbl_wl_ack[s] = it.ack;
        tbl_rcv_wnd[s] = sh_pref_win;
        tbl_state[s] = CONN_ESTAB;
        step_estab(s, it, r);
    endfunction

    function automatic void step_listen(int s, seg_t it, inout res_t r);
        int d;
        if ((it.flags & FLAG_SYN) == 0 || (it.flags & (FLAG_ACK | FLAG_RST | FLAG_FIN)) != 0) begin
            reset_reply(it, r);
            return;
        end
        d = first_closed();
        if (d < 0) begin
            reset_reply(it, r); r.status = STATUS_FULL; return;
        end
        // Spawn the connection from the listener, then take the peer's endpoint.
        tbl_state[d]   = tbl_state[s];
        tbl_laddr[d]   = tbl_laddr[s];
        tbl_lport[d]   = tbl_lport[s];
        tbl_snd_wnd[d] = tbl_snd_wnd[s];
        tbl_wl_seq[d]  = tbl_wl_seq[s];
        tbl_wl_ack[d]  = tbl_wl_ack[s];
        tbl_rcv_wnd[d] = tbl_rcv_wnd[s];
        tbl_raddr[d]   = it.src;
        tbl_rport[d]   = it.sport;
        tbl_isn[d]     = it.isn;
        tbl_ip_id[d]   = 16'(it.isn % 32'd65535);
        tbl_snd_una[d] = it.isn;
        tbl_snd_nxt[d] = it.isn + 32'd1;
        tbl_rcv_nxt[d] = it.seq + 32'd1;
        conn_reply(d, ACT_SYNACK, it.isn, tbl_rcv_nxt[d], FLAG_SYN | FLAG_ACK, r);
        tbl_state[d] = CONN_SYNRCVD;
        r.slot = 4'(d);
    endfunction

    // Predict the reply to one accepted segment and advance the shadow table.
    function automatic res_t predict_reply(seg_t it);
        res_t r;
        int n, hit, lsn;
        r = '0;
        hit = -1;
        lsn = -1;
        if (it.opcode) begin
            n = first_closed();
            if (n < 0) begin
                r.status = STATUS_FULL;
            end else begin
                tbl_laddr[n] = sh_local_addr;
                tbl_lport[n] = it.dport;
                tbl_raddr[n] = '0;
                tbl_rport[n] = '0;
                tbl_state[n] = CONN_LISTEN;
                r.lport = it.dport;
                r.slot = 4'(n);
            end
        end else if (it.cksum_ok) begin
            for (int i = 0; i < 16 && hit < 0; i++) begin
                if (it.dst != tbl_laddr[i] || it.dport != tbl_lport[i]) continue;
                if (tbl_state[i] == CONN_LISTEN) lsn = i;
                if (it.src != tbl_raddr[i] || it.sport != tbl_rport[i]) continue;
                hit = i;
            end
            if (hit < 0) hit = lsn;
            if (hit < 0) begin
                reset_reply(it, r);
                r.status = STATUS_NOMATCH;
            end else begin
                r.slot = 4'(hit);
                case (tbl_state[hit])
                    CONN_LISTEN:  step_listen(hit, it, r);
                    CONN_SYNRCVD: step_synrcvd(hit, it, r);
                    CONN_ESTAB:   step_estab(hit, it, r);
                    default: begin
                        reset_reply(it, r);
                        r.status = STATUS_NOMATCH;
                    end
                endcase
            end
        end
        return r;
    endfunction

    function automatic seg_t mk_seg(logic op, logic ck, logic [31:0] src, logic [31:0] dst,
                                    logic [15:0] sp, logic [15:0] dp, logic [31:0] sq,
                                    logic [31:0] ak, logic [5:0] fl, logic [15:0] wn,
                                    logic [15:0] ln, logic [31:0] isn);
        seg_t g;
        g.opcode = op; g.cksum_ok = ck; g.src = src; g.dst = dst; g.sport = sp; g.dport = dp;
        g.seq = sq; g.ack = ak; g.flags = fl; g.wnd = wn; g.len = ln; g.isn = isn;
        return g;
    endfunction

    task automatic queue_seg(seg_t g);
        pending_segs.push_back(g);
        items_sent++;
    endtask

    task automatic add_listener(logic [15:0] port);
        queue_seg(mk_seg(1'b1, $urandom, $urandom, $urandom, $urandom, port, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom));
        lst_addr.push_back(sh_local_addr);
        lst_port.push_back(port);
    endtask

    // Random segment, mostly with a good checksum, aimed at a known listener half the time.
    task automatic queue_noise();
        logic [31:0] dst;
        logic [15:0] dp;
        int li;
        dst = $urandom;
        dp = $urandom;
        if (lst_port.size() > 0 && $urandom_range(0, 1)) begin
            li = $urandom_range(0, lst_port.size() - 1);
            dst = lst_addr[li];
            dp = lst_port[li];
        end
        queue_seg(mk_seg(1'b0, $urandom_range(0, 9) != 0, $urandom, dst, $urandom, dp,
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    endtask

    // One connection lifetime: SYN, handshake ACK, some data, then teardown; some stop early.
    task automatic queue_session();
        logic [31:0] ra, la, rnext, snext, isn;
        logic [15:0] rp, lp, ln;
        logic [5:0]  fl;
        int li, k, m;
        seg_t g;
        if (lst_port.size() == 0) return;
        li = $urandom_range(0, lst_port.size() - 1);
        la = lst_addr[li];
        lp = lst_port[li];
        ra = $urandom;
        rp = $urandom;
        rnext = $urandom;
        isn = $urandom;
        fl = FLAG_SYN | (($urandom_range(0, 3) == 0) ? (FLAG_URG | FLAG_PSH) : 6'd0);
        queue_seg(mk_seg(1'b0, 1'b1, ra, la, rp, lp, rnext, $urandom, fl, $urandom, 16'd0, isn));
        if ($urandom_range(0, 99) < 3) return;
        rnext = rnext + 1;
        snext = isn + 1;
        queue_seg(mk_seg(1'b0, 1'b1, ra, la, rp, lp, rnext,
                         ($urandom_range(0, 9) == 0) ? isn : snext,
                         FLAG_ACK, $urandom, 16'd0, $urandom));
        k = $urandom_range(0, 6);
        for (int j = 0; j < k; j++) begin
            ln = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1460));
            g = mk_seg(1'b0, 1'b1, ra, la, rp, lp, rnext, snext, FLAG_ACK | FLAG_PSH,
                       $urandom, ln, $urandom);
            m = $urandom_range(0, 99);
            // Break some segments: off-sequence, ack ahead, bad checksum, odd flags, no data.
            if (m < 4) g.seq = rnext + $urandom_range(1, 20000);
            else if (m < 8) g.ack = snext + $urandom_range(1, 1000);
            else if (m < 11) g.cksum_ok = 1'b0;
            else if (m < 14) g.flags = ($urandom & ~FLAG_SYN & ~FLAG_RST & ~FLAG_FIN);
            else if (m < 16) g.len = 16'd0;
            queue_seg(g);
            if (m >= 4 && m < 8 || m >= 11) rnext = rnext + g.len;
        end
        m = $urandom_range(0, 99);
        if (m < 55)      fl = FLAG_ACK | FLAG_FIN;
        else if (m < 75) fl = FLAG_RST;
        else if (m < 90) fl = FLAG_SYN;
        else if (m < 94) return;
        else             fl = FLAG_ACK | FLAG_RST;
        queue_seg(mk_seg(1'b0, 1'b1, ra, la, rp, lp, rnext, snext, fl, $urandom,
                         16'd0, $urandom));
    endtask

    task automatic queue_random(int count);
        int target, m;
        target = items_sent + count;
        while (items_sent < target) begin
            m = $urandom_range(0, 99);
            if (m < 4 && lst_port.size() < 6) add_listener($urandom_range(0, 3) == 0 ?
                                                           16'hFFFF : 16'($urandom));
            else if (m < 25) queue_noise();
            else queue_session();
        end
    endtask

    // Wait for the engine to go quiet: no pending segments, no input valid, no open predictions.
    task automatic wait_drain();
        @(negedge aclk);
        while (pending_segs.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_LOCAL_ADDR: sh_local_addr = val;
            CFG_PREF_WIN:   sh_pref_win = val[15:0];
            CFG_MSS:        sh_mss = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Driver: present pending segments, with random gaps before each one.
    always @(posedge aclk) begin
        logic nxt_valid;
        seg_t cur;
        nxt_valid = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cur = pending_segs.pop_front();
                expected_replies.push_back(predict_reply(cur));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_segs.size() != 0 &&
                $urandom_range(0, 99) >= snd_idle_pct) begin
                cur = pending_segs[0];
                s_tdata <= {2'b00, cur.isn, cur.len, cur.wnd, cur.flags, cur.ack, cur.seq,
                            cur.dport, cur.sport, cur.dst, cur.src};
                s_tuser <= {cur.cksum_ok, cur.opcode};
                nxt_valid = 1'b1;
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Monitor: stall the result channel at random and check every transaction.
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.action  = m_tuser;
            got.seq     = m_tdata[31:0];
            got.ack     = m_tdata[63:32];
            got.flags   = m_tdata[69:64];
            got.window  = m_tdata[85:70];
            got.ip_id   = m_tdata[101:86];
            got.raddr   = m_tdata[133:102];
            got.rport   = m_tdata[149:134];
            got.lport   = m_tdata[165:150];
            got.deliver = m_tdata[181:166];
            got.slot    = m_tdata[185:182];
            got.status  = m_tdata[187:186];
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reply %p", got);
            end else begin
                want = expected_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: closed slot, no match, listener, handshake, data, teardown.
        queue_seg(mk_seg(0, 1, 0, 0, 0, 0, 0, 0, 6'd0, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 0, 0, 0, 0, 0, 0, FLAG_RST, 0, 0, 0));
        add_listener(16'd80);
        queue_seg(mk_seg(0, 0, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 0, 0, FLAG_SYN, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 1, 0, 2, 81, 5, 32'hFFFFFFFF, FLAG_ACK, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 1, 0, 2, 81, 32'hFFFFFFFF, 0, FLAG_SYN | FLAG_FIN, 0,
                         16'hFFFF, 0));
        queue_seg(mk_seg(0, 1, 7, 0, 7, 80, 3, 3, FLAG_ACK, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 32'hFFFFFFFF, 0, FLAG_SYN,
                         16'hFFFF, 0, 32'hFFFFFFFF));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 0, 5, FLAG_ACK, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 0, 0, 6'd0, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 0, 0, FLAG_ACK, 16'hFFFF, 0, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 0, 0,
                         FLAG_ACK | FLAG_PSH | FLAG_URG, 16'hFFFF, 100, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 32'h80000000, 0, FLAG_ACK,
                         0, 10, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 110, 0, FLAG_ACK, 0, 10, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 100, 100, FLAG_ACK, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 100, 0, FLAG_ACK, 0,
                         16'hFFFF, 0));
        queue_seg(mk_seg(0, 1, 32'hFFFFFFFF, 0, 16'hFFFF, 80, 8292, 0, FLAG_ACK | FLAG_FIN,
                         0, 0, 0));
        queue_seg(mk_seg(0, 1, 9, 0, 9, 80, 1000, 0, FLAG_SYN, 0, 0, 32'd65535));
        queue_seg(mk_seg(0, 1, 9, 0, 9, 80, 1001, 65536, FLAG_ACK, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 9, 0, 9, 80, 1001, 65536, FLAG_RST, 0, 0, 0));
        queue_seg(mk_seg(0, 1, 11, 0, 11, 80, 50, 0, FLAG_SYN, 0, 0, 32'd123));
        queue_seg(mk_seg(0, 1, 11, 0, 11, 80, 51, 0, FLAG_SYN, 0, 0, 0));
        wait_drain();

        // Widest window, smallest MSS, sender idling.
        write_reg(CFG_LOCAL_ADDR, $urandom);
        write_reg(CFG_PREF_WIN, 32'd65535);
        write_reg(CFG_MSS, 32'd1);
        snd_idle_pct = 77;
        add_listener(16'($urandom));
        queue_random(200);
        wait_drain();

        // Closed window, largest MSS, receiver stalling.
        write_reg(CFG_PREF_WIN, 32'd0);
        write_reg(CFG_MSS, 32'd65535);
        snd_idle_pct = 0;
        rcv_stall_pct = 77;
        queue_random(80);
        wait_drain();

        // Random window and MSS on an all-ones address, both sides idling.
        write_reg(CFG_LOCAL_ADDR, 32'hFFFFFFFF);
        write_reg(CFG_PREF_WIN, $urandom_range(1, 65535));
        write_reg(CFG_MSS, $urandom_range(1, 65535));
        snd_idle_pct = 14;
        rcv_stall_pct = 14;
        add_listener(16'd0);
        queue_random(200);
        wait_drain();

        // Defaults again at full rate, then fill the table.
        write_reg(CFG_LOCAL_ADDR, 32'd0);
        write_reg(CFG_PREF_WIN, 32'd8192);
        write_reg(CFG_MSS, 32'd536);
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        queue_random(180);
        for (int i = 0; i < 18; i++) add_listener(16'($urandom));
        for (int i = 0; i < 4; i++) queue_session();
        wait_drain();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
